>>> design/tss_pkg.sv
// ----------------------------------------------------------------------------
// Tone sweep package
// Shared types, register codes, reset values and the sine table builder.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TONE_SLOTS  = 5;
    localparam int STEP_W      = 31;
    localparam int LEN_W       = 20;
    localparam int AMP_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int TONE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_A    = 3'd0,
        CFG_STEP_B    = 3'd1,
        CFG_STEP_C    = 3'd2,
        CFG_STEP_D    = 3'd3,
        CFG_STEP_E    = 3'd4,
        CFG_SAMPLES   = 3'd5,
        CFG_AMPLITUDE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TONE_SLOTS-1:0][STEP_W-1:0] step;
        logic [LEN_W-1:0]                  spt;
        logic [AMP_W-1:0]                  amp;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        step: {31'd1431655765, 31'd715827883, 31'd357913941,
               31'd178956971, 31'd89478485},
        spt:  20'd48000,
        amp:  15'd32000
    };

    // Per-sample tag that travels with the phase
    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic              last;
    } t_tag;

    // Sine table entry k of a 2^tb table, Q30, quarter-wave mirrored.
    // Evaluated at elaboration only.
    function automatic logic signed [31:0] rom_q30(input int unsigned k,
                                                   input int unsigned tb);
        longint unsigned quarter;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        quarter = 64'd1 << (tb - 2);
        quad    = (longint'(k) >> (tb - 2)) & 64'd3;
        r       = longint'(k) & (quarter - 64'd1);
        if (quad[0]) begin
            r = quarter - r;
        end
        x    = (r * HALF_PI_Q30) >> (tb - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - longint'(term);
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (quad[1]) begin
            sum = -sum;
        end
        return 32'(sum);
    endfunction

endpackage

>>> design/tss_ifs.sv
// ----------------------------------------------------------------------------
// Tone sweep channel interfaces
// Sample tick input, sample output and register write channels.
// ----------------------------------------------------------------------------
interface tss_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface tss_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [2:0]         tone_number;
    logic               sweep_last;

    modport source (output valid, output sample, output tone_number,
                    output sweep_last, input ready);
    modport sink   (input valid, input sample, input tone_number,
                    input sweep_last, output ready);
endinterface

interface tss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/tss_queue.sv
// ----------------------------------------------------------------------------
// Tone sweep queue
// Small register FIFO between the sequencing front and the synthesis back.
// ----------------------------------------------------------------------------
module tss_queue #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_pop;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;
    assign n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/tss_front.sv
// ----------------------------------------------------------------------------
// Tone sweep front
// Takes sample ticks, sequences tone, sample count and phase, pushes one
// phase and tag per beat into the queue.
// ----------------------------------------------------------------------------
module tss_front import tss_pkg::*; #(
    parameter int TONE_COUNT  = 5,
    parameter int PHASE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tss_tick_if.sink               i_tick,
    input  t_cfg                   i_cfg,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [PHASE_WIDTH-1:0] o_phase,
    output t_tag                   o_tag
);

    logic [TONE_W-1:0]      r_tone;
    logic [LEN_W-1:0]       r_cnt;
    logic [PHASE_WIDTH-1:0] r_phase;

    logic [TONE_W-1:0]      e_tone;
    logic [LEN_W-1:0]       e_cnt;
    logic [PHASE_WIDTH-1:0] e_phase;
    logic [LEN_W-1:0]       w_len;
    logic                   w_last;
    logic [STEP_W-1:0]      w_step;
    logic [PHASE_WIDTH-1:0] w_step_ph;
    logic [TONE_W-1:0]      n_tone;
    logic [LEN_W-1:0]       n_cnt;
    logic [PHASE_WIDTH-1:0] n_phase;

    assign i_tick.ready = !i_full;
    assign o_push       = i_tick.valid && !i_full;

    // Bring the 2^32-scaled step to the accumulator width
    if (PHASE_WIDTH >= 32) begin : g_step_up
        assign w_step_ph = PHASE_WIDTH'({1'b0, w_step}) << (PHASE_WIDTH - 32);
    end else begin : g_step_dn
        assign w_step_ph = PHASE_WIDTH'({1'b0, w_step} >> (32 - PHASE_WIDTH));
    end

    always_comb begin
        e_tone  = i_tick.restart ? '0 : r_tone;
        e_cnt   = i_tick.restart ? '0 : r_cnt;
        e_phase = i_tick.restart ? '0 : r_phase;
        // A zero length plays as one sample
        w_len   = (i_cfg.spt == '0) ? LEN_W'(1) : i_cfg.spt;
        w_last  = ({1'b0, e_cnt} + (LEN_W+1)'(1)) >= {1'b0, w_len};
        case (e_tone)
            3'd1:    w_step = i_cfg.step[1];
            3'd2:    w_step = i_cfg.step[2];
            3'd3:    w_step = i_cfg.step[3];
            3'd4:    w_step = i_cfg.step[4];
            default: w_step = i_cfg.step[0];
        endcase
        if (w_last) begin
            n_cnt   = '0;
            n_phase = '0;
            n_tone  = (({1'b0, e_tone} + 4'd1) >= 4'(TONE_COUNT)) ? '0 : e_tone + 1'b1;
        end else begin
            n_cnt   = e_cnt + 1'b1;
            n_phase = e_phase + w_step_ph;
            n_tone  = e_tone;
        end
        o_phase   = e_phase;
        o_tag.tone = e_tone;
        o_tag.last = w_last && (e_tone == TONE_W'(TONE_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone  <= '0;
            r_cnt   <= '0;
            r_phase <= '0;
        end else if (o_push) begin
            r_tone  <= n_tone;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

endmodule

>>> design/tss_back.sv
// ----------------------------------------------------------------------------
// Tone sweep back
// Sine table lookup, linear interpolation and amplitude scaling in a
// five-stage pipeline that stalls as a whole on output backpressure.
// ----------------------------------------------------------------------------
module tss_back import tss_pkg::*; #(
    parameter int TONE_COUNT      = 5,
    parameter int SINE_TABLE_BITS = 12,
    parameter int PHASE_WIDTH     = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [PHASE_WIDTH-1:0] i_phase,
    input  t_tag                   i_tag,
    output logic                   o_pop,
    input  logic [AMP_W-1:0]       i_amp,
    tss_smp_if.source              o_smp
);

    localparam int ROM_SIZE  = 2 ** SINE_TABLE_BITS;
    localparam int FRAC_BITS = PHASE_WIDTH - SINE_TABLE_BITS;

    logic signed [31:0] w_rom [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam logic signed [31:0] ROM_VAL = rom_q30(g, SINE_TABLE_BITS);
        assign w_rom[g] = ROM_VAL;
    end

    logic                       w_ce;
    logic [PHASE_WIDTH+15:0]    w_ext;

    logic                       r_v1;
    logic [SINE_TABLE_BITS-1:0] r_k0;
    logic [SINE_TABLE_BITS-1:0] r_k1;
    logic [15:0]                r_frac1;
    t_tag                       r_tag1;

    logic                       r_v2;
    logic signed [31:0]         r_s0_2;
    logic signed [31:0]         r_s1_2;
    logic [15:0]                r_frac2;
    t_tag                       r_tag2;

    logic                       r_v3;
    logic signed [49:0]         r_prod3;
    logic signed [31:0]         r_s0_3;
    t_tag                       r_tag3;

    logic                       r_v4;
    logic signed [47:0]         r_scaled4;
    t_tag                       r_tag4;

    logic                       r_out_valid;
    logic signed [15:0]         r_sample;
    t_tag                       r_tag;

    logic signed [32:0]         w_diff;
    logic signed [49:0]         w_prod;
    logic signed [49:0]         w_q;
    logic signed [31:0]         w_interp;
    logic signed [47:0]         w_scaled;
    logic signed [47:0]         w_round;
    logic signed [47:0]         w_val;

    // Advance every stage together when the output register can take a beat
    assign w_ce  = !r_out_valid || o_smp.ready;
    assign o_pop = w_ce;
    assign w_ext = {i_phase, 16'd0};

    assign w_diff   = 33'(r_s1_2) - 33'(r_s0_2);
    assign w_prod   = w_diff * $signed({1'b0, r_frac2});
    // Divide by 2^16 rounding toward zero
    assign w_q      = (r_prod3 + (r_prod3[49] ? 50'sd65535 : 50'sd0)) >>> 16;
    assign w_interp = r_s0_3 + $signed(w_q[31:0]);
    assign w_scaled = $signed({1'b0, i_amp}) * w_interp;
    // Divide by 2^30 rounding toward zero
    assign w_round  = r_scaled4 + (r_scaled4[47] ? 48'sd1073741823 : 48'sd0);
    assign w_val    = w_round >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_k0      <= i_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
            r_k1      <= i_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS] + 1'b1;
            r_frac1   <= w_ext[FRAC_BITS +: 16];
            r_tag1    <= i_tag;
            r_s0_2    <= w_rom[r_k0];
            r_s1_2    <= w_rom[r_k1];
            r_frac2   <= r_frac1;
            r_tag2    <= r_tag1;
            r_prod3   <= w_prod;
            r_s0_3    <= r_s0_2;
            r_tag3    <= r_tag2;
            r_scaled4 <= w_scaled;
            r_tag4    <= r_tag3;
            r_sample  <= w_val[15:0];
            r_tag     <= r_tag4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    assign o_smp.valid       = r_out_valid;
    assign o_smp.sample      = r_sample;
    assign o_smp.tone_number = r_tag.tone;
    assign o_smp.sweep_last  = r_tag.last;

`ifndef SYNTHESIS
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ce && r_v4) |=> r_out_valid)
        else $error("pipeline dropped a sample at the output stage");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sample != 16'sh8000))
        else $error("sample outside symmetric range");

    a_tone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_tag.tone} < 4'(TONE_COUNT)))
        else $error("tone number beyond tone count");

    a_last_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tag.last) |-> (r_tag.tone == TONE_W'(TONE_COUNT - 1)))
        else $error("sweep end flagged on a tone other than the last");
`endif

endmodule

>>> design/tone_sweep_sine_generator_core.sv
// ----------------------------------------------------------------------------
// Tone sweep sine generator core
// Plays a fixed list of tones in turn, one signed sine sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick  - one beat per sample tick; restart=1 jumps to tone 0, phase 0.
//   o_smp   - one beat per tick: sample, tone_number and sweep_last.
//   i_cfg   - register writes (steps of tones 0..4, samples per tone,
//             amplitude); always ready, write only while the block is idle.
// Throughput: one tick per cycle while the queue is not full, set by the
//   phase and count update in the front stage.
// Path: a tick accepted on i_tick passes the queue, table address, table
//   read, interpolate, scale and output registers before o_smp.valid.
// Reset: registers take their default values, the sweep returns to tone 0
//   at phase 0, queue and pipeline empty. No clearing pass.
// Stall: with o_smp.valid high and ready low the back pipeline holds;
//   ticks keep filling the 4-entry queue; i_tick.ready drops only when full.
// ----------------------------------------------------------------------------
module tone_sweep_sine_generator_core import tss_pkg::*; #(
    parameter int TONE_COUNT      = 5,
    parameter int SINE_TABLE_BITS = 12,
    parameter int PHASE_WIDTH     = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_tick_if.sink  i_tick,
    tss_smp_if.source o_smp,
    tss_cfg_if.sink   i_cfg
);

    localparam int Q_W = PHASE_WIDTH + $bits(t_tag);

    t_cfg                   r_cfg;
    logic                   w_push;
    logic [PHASE_WIDTH-1:0] w_push_phase;
    t_tag                   w_push_tag;
    logic                   w_full;
    logic                   w_pop;
    logic                   w_q_valid;
    logic [Q_W-1:0]         w_q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_STEP_A:    r_cfg.step[0] <= i_cfg.data[STEP_W-1:0];
                CFG_STEP_B:    r_cfg.step[1] <= i_cfg.data[STEP_W-1:0];
                CFG_STEP_C:    r_cfg.step[2] <= i_cfg.data[STEP_W-1:0];
                CFG_STEP_D:    r_cfg.step[3] <= i_cfg.data[STEP_W-1:0];
                CFG_STEP_E:    r_cfg.step[4] <= i_cfg.data[STEP_W-1:0];
                CFG_SAMPLES:   r_cfg.spt     <= i_cfg.data[LEN_W-1:0];
                CFG_AMPLITUDE: r_cfg.amp     <= i_cfg.data[AMP_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    tss_front #(
        .TONE_COUNT  (TONE_COUNT),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (i_tick),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_phase (w_push_phase),
        .o_tag   (w_push_tag)
    );

    tss_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_phase, w_push_tag}),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data)
    );

    tss_back #(
        .TONE_COUNT      (TONE_COUNT),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_WIDTH     (PHASE_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_phase (w_q_data[Q_W-1 -: PHASE_WIDTH]),
        .i_tag   (t_tag'(w_q_data[$bits(t_tag)-1:0])),
        .o_pop   (w_pop),
        .i_amp   (r_cfg.amp),
        .o_smp   (o_smp)
    );

endmodule
